[rtl/clock_replacement_doc_cache_top_assert.svh]
// Assertion helpers used by the cache controller.
`ifndef CLOCK_REPLACEMENT_DOC_CACHE_TOP_ASSERT_SVH
`define CLOCK_REPLACEMENT_DOC_CACHE_TOP_ASSERT_SVH

// Consequent holds in the same cycle.
`define CRDC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the next cycle.
`define CRDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/crdc_pkg.sv]
`timescale 1ns / 1ps
package crdc_pkg;

    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_W   = 64;
    localparam int HANDLE_W = 32;
    localparam int REV_W   = 32;
    localparam int USED_W  = 4;

    localparam logic CFG_PRECACHE_ALL    = 1'b0;
    localparam logic CFG_CACHE_NOT_FOUND = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_FILL   = 2'd1,
        ACT_CHANGE = 2'd2,
        ACT_ERASE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        OP_REPORT,
        OP_TOUCH,
        OP_ABSENT,
        OP_STORE,
        OP_ERASE,
        OP_IDLE
    } t_op;

    typedef struct packed {
        logic load;
        logic match;
        logic sweep;
        logic apply;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic    hit;
        logic    sweep_free;
        t_action action;
        logic    not_found;
        logic    is_idle;
    } t_status;

endpackage

[rtl/crdc_datapath.sv]
`timescale 1ns / 1ps
module crdc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crdc_pkg::t_cmd                i_cmd,
    output crdc_pkg::t_status             o_status,
    input  logic [1:0]                    i_action,
    input  logic [crdc_pkg::KEY_W-1:0]    i_doc_key,
    input  logic [crdc_pkg::HANDLE_W-1:0] i_doc_handle,
    input  logic [crdc_pkg::REV_W-1:0]    i_doc_revision,
    input  logic                          i_is_deleted,
    input  logic                          i_not_found,
    input  logic                          i_is_idle,
    output logic                          o_hit,
    output logic                          o_absent_mark,
    output logic [crdc_pkg::HANDLE_W-1:0] o_found_handle,
    output logic                          o_stale_rejected,
    output logic                          o_evicted,
    output logic [crdc_pkg::USED_W-1:0]   o_slot_used
);

    localparam int S  = crdc_pkg::SLOTS;
    localparam int SW = crdc_pkg::SLOT_W;

    logic [S-1:0]                    r_valid;
    logic [S-1:0]                    r_acc;
    logic [S-1:0]                    r_absent;
    logic [crdc_pkg::KEY_W-1:0]      r_key    [S];
    logic [crdc_pkg::HANDLE_W-1:0]   r_handle [S];
    logic [crdc_pkg::REV_W-1:0]      r_rev    [S];
    logic [SW-1:0]                   r_hand;

    // latched transaction
    crdc_pkg::t_action               r_in_act;
    logic [crdc_pkg::KEY_W-1:0]      r_in_key;
    logic [crdc_pkg::HANDLE_W-1:0]   r_in_handle;
    logic [crdc_pkg::REV_W-1:0]      r_in_rev;
    logic                            r_in_del;
    logic                            r_in_nf;
    logic                            r_in_idle;

    logic                            r_hit;
    logic [SW-1:0]                   r_idx;
    logic                            r_took;
    logic [SW-1:0]                   r_take_idx;
    logic                            r_take_ev;

    logic                            match_any;
    logic [SW-1:0]                   match_idx;
    logic [SW-1:0]                   n_hand;
    logic                            hand_free;

    logic [SW-1:0]                   sidx;
    logic                            show;
    logic                            used_en;
    logic                            hit_out;
    logic                            stale;
    logic                            wr_slot;
    logic                            n_abs;
    logic [crdc_pkg::HANDLE_W-1:0]   n_handle;
    logic [crdc_pkg::REV_W-1:0]      n_rev;

    always_comb begin
        match_any = 1'b0;
        match_idx = '0;
        for (int i = S - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == r_in_key)) begin
                match_any = 1'b1;
                match_idx = SW'(i);
            end
        end
    end

    assign n_hand    = (r_hand == SW'(S - 1)) ? '0 : r_hand + 1'b1;
    assign hand_free = !r_valid[r_hand] || !r_acc[r_hand];

    assign o_status.hit        = r_hit;
    assign o_status.sweep_free = hand_free;
    assign o_status.action     = r_in_act;
    assign o_status.not_found  = r_in_nf;
    assign o_status.is_idle    = r_in_idle;

    always_comb begin
        sidx     = r_took ? r_take_idx : r_idx;
        show     = 1'b0;
        hit_out  = r_hit;
        stale    = 1'b0;
        wr_slot  = 1'b0;
        n_abs    = r_absent[sidx];
        n_handle = r_handle[sidx];
        n_rev    = r_rev[sidx];
        case (i_cmd.op)
            crdc_pkg::OP_REPORT,
            crdc_pkg::OP_TOUCH: begin
                show = r_hit;
            end
            crdc_pkg::OP_ABSENT: begin
                show     = 1'b1;
                wr_slot  = 1'b1;
                n_abs    = 1'b1;
                n_handle = '0;
                if (!r_hit) begin
                    n_rev = '0;
                end
            end
            crdc_pkg::OP_STORE: begin
                show = 1'b1;
                if (!r_hit || (r_in_rev > r_rev[sidx])) begin
                    wr_slot  = 1'b1;
                    n_abs    = r_in_del;
                    n_handle = r_in_del ? '0 : r_in_handle;
                    n_rev    = r_in_rev;
                end else begin
                    stale = 1'b1;
                end
            end
            crdc_pkg::OP_ERASE: begin
                show = 1'b0;
            end
            crdc_pkg::OP_IDLE: begin
                hit_out = 1'b0;
            end
            default: begin
                show = 1'b0;
            end
        endcase
        used_en = show || ((i_cmd.op == crdc_pkg::OP_ERASE) && r_hit);
    end

    // control state: valid, accessed, hand, match and sweep results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_acc   <= '0;
            r_hand  <= '0;
            r_took  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_took <= 1'b0;
            end
            if (i_cmd.match) begin
                r_hit <= match_any;
            end
            if (i_cmd.sweep) begin
                r_hand <= n_hand;
                if (hand_free) begin
                    r_took <= 1'b1;
                end else begin
                    r_acc[r_hand] <= 1'b0;
                end
            end
            if (i_cmd.apply) begin
                if (r_took) begin
                    r_valid[sidx] <= 1'b1;
                    r_acc[sidx]   <= 1'b0;
                end
                if (i_cmd.op == crdc_pkg::OP_TOUCH) begin
                    r_acc[sidx] <= 1'b1;
                end
                if ((i_cmd.op == crdc_pkg::OP_ERASE) && r_hit) begin
                    r_valid[sidx] <= 1'b0;
                    r_acc[sidx]   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_act    <= crdc_pkg::t_action'(i_action);
            r_in_key    <= i_doc_key;
            r_in_handle <= i_doc_handle;
            r_in_rev    <= i_doc_revision;
            r_in_del    <= i_is_deleted;
            r_in_nf     <= i_not_found;
            r_in_idle   <= i_is_idle;
        end
        if (i_cmd.match) begin
            r_idx <= match_idx;
        end
        if (i_cmd.sweep && hand_free) begin
            r_take_idx <= r_hand;
            r_take_ev  <= r_valid[r_hand];
        end
        if (i_cmd.apply) begin
            if (r_took) begin
                r_key[sidx] <= r_in_key;
            end
            if (wr_slot) begin
                r_absent[sidx] <= n_abs;
                r_handle[sidx] <= n_handle;
                r_rev[sidx]    <= n_rev;
            end
            o_hit            <= hit_out;
            o_absent_mark    <= show ? n_abs : 1'b0;
            o_found_handle   <= (show && !n_abs) ? n_handle : '0;
            o_stale_rejected <= stale;
            o_evicted        <= r_took && r_take_ev;
            o_slot_used      <= used_en ? crdc_pkg::USED_W'(sidx) : '0;
        end
    end

endmodule

[rtl/crdc_ctrl.sv]
`timescale 1ns / 1ps
module crdc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    output logic                 o_done,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic                 i_cfg_data,
    input  crdc_pkg::t_status    i_status,
    output crdc_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_SWEEP,
        S_APPLY
    } t_state;

    t_state          r_state;
    crdc_pkg::t_op   r_op;
    logic            r_done;
    logic            r_precache;
    logic            r_cache_nf;
    crdc_pkg::t_op   n_op;
    logic            n_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_precache <= 1'b0;
            r_cache_nf <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                crdc_pkg::CFG_PRECACHE_ALL:    r_precache <= i_cfg_data;
                crdc_pkg::CFG_CACHE_NOT_FOUND: r_cache_nf <= i_cfg_data;
                default:                       r_precache <= r_precache;
            endcase
        end
    end

    always_comb begin
        n_op   = crdc_pkg::OP_REPORT;
        n_take = 1'b0;
        case (i_status.action)
            crdc_pkg::ACT_LOOKUP: begin
                n_op = i_status.hit ? crdc_pkg::OP_TOUCH : crdc_pkg::OP_REPORT;
            end
            crdc_pkg::ACT_FILL: begin
                if (i_status.not_found) begin
                    if (r_cache_nf) begin
                        n_op   = crdc_pkg::OP_ABSENT;
                        n_take = !i_status.hit;
                    end
                end else begin
                    n_op   = crdc_pkg::OP_STORE;
                    n_take = !i_status.hit;
                end
            end
            crdc_pkg::ACT_CHANGE: begin
                if (i_status.is_idle) begin
                    n_op = crdc_pkg::OP_IDLE;
                end else if (r_precache || i_status.hit) begin
                    n_op   = crdc_pkg::OP_STORE;
                    n_take = !i_status.hit;
                end
            end
            crdc_pkg::ACT_ERASE: begin
                n_op = crdc_pkg::OP_ERASE;
            end
            default: begin
                n_op = crdc_pkg::OP_REPORT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= crdc_pkg::OP_REPORT;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_op    <= n_op;
                    r_state <= n_take ? S_SWEEP : S_APPLY;
                end
                S_SWEEP: begin
                    // hand passes accessed slots, clearing them
                    if (i_status.sweep_free) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_cmd.load  = (r_state == S_IDLE) && i_start;
    assign o_cmd.match = (r_state == S_MATCH);
    assign o_cmd.sweep = (r_state == S_SWEEP);
    assign o_cmd.apply = (r_state == S_APPLY);
    assign o_cmd.op    = r_op;

`include "clock_replacement_doc_cache_top_assert.svh"

    `CRDC_ASSERT_NEXT(a_accept_busy, o_cmd.load, o_busy, "accepted transaction did not go busy")
    `CRDC_ASSERT_NEXT(a_apply_done, o_cmd.apply, o_done, "apply without result strobe")
    `CRDC_ASSERT_NOW(a_done_idle, o_done, !o_busy, "result strobe while busy")
    `CRDC_ASSERT_NEXT(a_sweep_exit, o_cmd.sweep && i_status.sweep_free, o_cmd.apply,
                      "free slot found but no apply")

endmodule

[rtl/clock_replacement_doc_cache_top.sv]
// A transaction passes from accept through the match and decide states, an optional sweep state
// for a new key in which the clock hand visits slots until one is free, and the apply state.
// One transaction is in flight at a time; start is taken in the o_done cycle.
// The sweep is bound by the hand examining one slot per cycle.
// o_done is high for a single cycle and cannot be stalled; results hold until the next apply.
// Reset (synchronous, active low) empties all slots, clears accessed bits, hand and config.
`timescale 1ns / 1ps
module clock_replacement_doc_cache_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          o_done,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic                          i_cfg_data,
    input  logic [1:0]                    i_action,
    input  logic [crdc_pkg::KEY_W-1:0]    i_doc_key,
    input  logic [crdc_pkg::HANDLE_W-1:0] i_doc_handle,
    input  logic [crdc_pkg::REV_W-1:0]    i_doc_revision,
    input  logic                          i_is_deleted,
    input  logic                          i_not_found,
    input  logic                          i_is_idle,
    output logic                          o_hit,
    output logic                          o_absent_mark,
    output logic [crdc_pkg::HANDLE_W-1:0] o_found_handle,
    output logic                          o_stale_rejected,
    output logic                          o_evicted,
    output logic [crdc_pkg::USED_W-1:0]   o_slot_used
);

    crdc_pkg::t_cmd    cmd;
    crdc_pkg::t_status status;

    crdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .o_done     (o_done),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    crdc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_action         (i_action),
        .i_doc_key        (i_doc_key),
        .i_doc_handle     (i_doc_handle),
        .i_doc_revision   (i_doc_revision),
        .i_is_deleted     (i_is_deleted),
        .i_not_found      (i_not_found),
        .i_is_idle        (i_is_idle),
        .o_hit            (o_hit),
        .o_absent_mark    (o_absent_mark),
        .o_found_handle   (o_found_handle),
        .o_stale_rejected (o_stale_rejected),
        .o_evicted        (o_evicted),
        .o_slot_used      (o_slot_used)
    );

endmodule
